// ===== rtl/core/utf8dc_pkg.sv =====
// shared types and constants for the utf-8 decoder and width classifier
`default_nettype none

package utf8dc_pkg;

   // width classes reported on the final byte of a string
   localparam logic [2:0] CLASS_ASCII   = 3'd0;
   localparam logic [2:0] CLASS_BYTE    = 3'd1;
   localparam logic [2:0] CLASS_WORD    = 3'd2;
   localparam logic [2:0] CLASS_WIDE    = 3'd3;
   localparam logic [2:0] CLASS_INVALID = 3'd4;

   // byte and code point limits
   localparam logic [7:0]  BYTE_ASCII_MAX = 8'h7F;
   localparam logic [7:0]  BYTE_CONT_MIN  = 8'h80;
   localparam logic [7:0]  BYTE_BAD_MAX   = 8'hC1;
   localparam logic [7:0]  BYTE_LEAD2_END = 8'hE0;
   localparam logic [7:0]  BYTE_LEAD3_END = 8'hF0;
   localparam logic [7:0]  BYTE_LEAD4_END = 8'hF8;
   localparam logic [20:0] CODE_ASCII_MAX = 21'h00007F;
   localparam logic [20:0] CODE_BYTE_MAX  = 21'h0000FF;
   localparam logic [20:0] CODE_WORD_MAX  = 21'h00FFFF;
   localparam logic [15:0] COUNT_OUT_MAX  = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        code_ready;
      logic [20:0] code_value;
      logic        string_end;
      logic [2:0]  string_class;
      logic [15:0] code_count;
      logic        had_error;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/utf8_decode_and_classify.sv =====
// top level: streaming utf-8 decoder with per-string width classification
// an accepted byte's result beat is registered and appears on rsp in the next cycle
// throughput: one byte per cycle while rsp is not stalled; the result register drains while the next byte loads
// reset: synchronous, active high; clears decoder state, the mode register and rsp_valid
// after reset the block takes a byte in the very first cycle, no clearing pass
`default_nettype none

module utf8_decode_and_classify
   import utf8dc_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   // input byte channel
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   // result channel
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   // mode register
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   // decoder phase codes; anything above the deepest wait behaves as aborted
   localparam logic [2:0] PH_ACCEPT = 3'd0;
   localparam logic [2:0] PH_ABORT  = 3'd1;
   localparam logic [2:0] PH_WAIT1  = 3'd2;
   localparam logic [2:0] PH_WAIT2  = 3'd3;
   localparam logic [2:0] PH_WAIT3  = 3'd4;

   // wide enough view of the count for saturating into the 16-bit field
   localparam int COUNT_WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] COUNT_SAT = {COUNT_BITS{1'b1}};

   // mode register
   logic recover_ff;

   // per-string state
   logic [2:0]            phase_ff,   phase_in;
   logic [20:0]           partial_ff, partial_in;
   logic [20:0]           largest_ff, largest_in;
   logic [COUNT_BITS-1:0] count_ff,   count_in;
   logic                  error_ff,   error_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff,       rsp_in;

   // per-byte decode results
   logic        accept;
   logic        ready;
   logic        bad;
   logic [20:0] value;
   logic [20:0] shifted;
   logic [7:0]  data;
   logic [COUNT_WIDE-1:0] count_wide;

   function automatic logic [2:0] recover_on_error_phase(input logic recover);
      return recover ? PH_ACCEPT : PH_ABORT;
   endfunction

   // take a byte unless in reset, or a result is held and the far side is stalling
   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign data      = req_payload.data_byte;

   // continuation folds six payload bits in under the partial code
   assign shifted = {partial_ff[14:0], data[5:0]};

   // byte decode: lead/continuation state machine
   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      ready      = 1'b0;
      bad        = 1'b0;
      value      = '0;
      unique case (phase_ff) inside
         PH_ACCEPT: begin
            if (data <= BYTE_ASCII_MAX) begin
               ready = 1'b1;
               value = {13'd0, data};
            end else if (data <= BYTE_BAD_MAX || data >= BYTE_LEAD4_END) begin
               // stray continuation, overlong two-byte lead or five-plus byte lead
               bad = 1'b1;
            end else if (data < BYTE_LEAD2_END) begin
               partial_in = {16'd0, data[4:0]};
               phase_in   = PH_WAIT1;
            end else if (data < BYTE_LEAD3_END) begin
               partial_in = {17'd0, data[3:0]};
               phase_in   = PH_WAIT2;
            end else begin
               partial_in = {18'd0, data[2:0]};
               phase_in   = PH_WAIT3;
            end
         end
         PH_WAIT1, PH_WAIT2, PH_WAIT3: begin
            if (data[7:6] != BYTE_CONT_MIN[7:6]) begin
               bad = 1'b1;
            end else begin
               partial_in = shifted;
               if (phase_ff == PH_WAIT1) begin
                  phase_in = PH_ACCEPT;
                  ready    = 1'b1;
                  value    = shifted;
               end else begin
                  phase_in = phase_ff - 3'd1;
               end
            end
         end
         default: begin
            // aborted string: swallow bytes until the final one
            phase_in = PH_ABORT;
         end
      endcase
      if (bad) begin
         phase_in = recover_on_error_phase(recover_ff);
      end
   end

   // running maximum, saturating count and sticky error flag
   always_comb begin
      largest_in = largest_ff;
      count_in   = count_ff;
      error_in   = error_ff | bad;
      if (ready) begin
         if (value > largest_ff) begin
            largest_in = value;
         end
         if (count_ff != COUNT_SAT) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   assign count_wide = COUNT_WIDE'(count_in);

   // result beat for this byte
   always_comb begin
      rsp_in              = '0;
      rsp_in.code_ready   = ready;
      rsp_in.code_value   = value;
      rsp_in.string_end   = req_payload.last_byte;
      if (req_payload.last_byte) begin
         rsp_in.had_error = error_in;
         if (phase_in == PH_ABORT) begin
            rsp_in.string_class = CLASS_INVALID;
         end else begin
            if (largest_in > CODE_WORD_MAX) begin
               rsp_in.string_class = CLASS_WIDE;
            end else if (largest_in > CODE_BYTE_MAX) begin
               rsp_in.string_class = CLASS_WORD;
            end else if (largest_in > CODE_ASCII_MAX) begin
               rsp_in.string_class = CLASS_BYTE;
            end else begin
               rsp_in.string_class = CLASS_ASCII;
            end
            // the port field is 16 bits whatever the internal count width
            if (count_wide > COUNT_WIDE'(COUNT_OUT_MAX)) begin
               rsp_in.code_count = COUNT_OUT_MAX;
            end else begin
               rsp_in.code_count = count_wide[15:0];
            end
         end
      end
   end

   // result register holds until taken, reloads when a byte is accepted
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recover_ff   <= 1'b0;
         phase_ff     <= PH_ACCEPT;
         partial_ff   <= '0;
         largest_ff   <= '0;
         count_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            recover_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_payload.last_byte) begin
               // final byte closes the string: trailing partial sequence dropped
               phase_ff   <= PH_ACCEPT;
               partial_ff <= '0;
               largest_ff <= '0;
               count_ff   <= '0;
               error_ff   <= 1'b0;
            end else begin
               phase_ff   <= phase_in;
               partial_ff <= partial_in;
               largest_ff <= largest_in;
               count_ff   <= count_in;
               error_ff   <= error_in;
            end
         end
      end
   end

   // payload register needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/utf8dc_checker.sv =====
// port-level checker for the utf-8 decoder, bound to the top level
`default_nettype none

module utf8dc_checker
   import utf8dc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   // no beat held straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // every accepted byte yields a beat on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted byte produced no result beat");

   // no code point means a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.code_ready) |-> (rsp_payload.code_value == 21'd0))
      else $error("code value set without a completed code point");

   // summary fields are quiet before the final byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.string_end) |->
      (rsp_payload.string_class == CLASS_ASCII && rsp_payload.code_count == 16'd0
       && !rsp_payload.had_error))
      else $error("summary fields set mid-string");

   // an aborted string reports an error and no code points
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.string_end && rsp_payload.string_class == CLASS_INVALID)
      |-> (rsp_payload.had_error && rsp_payload.code_count == 16'd0))
      else $error("invalid string reported without error or with a count");

endmodule

bind utf8_decode_and_classify utf8dc_checker u_utf8dc_checker (.*);

`default_nettype wire
